[design/csvt_pkg.sv]
// Shared types, constants and helper functions of the CSV field tokenizer.
package csvt_pkg;

   localparam int FIELD_MAX_DEFAULT = 64;

   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;

   localparam logic [1:0] KIND_SPACE = 2'd0;
   localparam logic [1:0] KIND_TAB   = 2'd1;
   localparam logic [1:0] KIND_VT    = 2'd2;
   localparam logic [1:0] KIND_FF    = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPACE,
      ST_BYTE
   } state_type;

   typedef struct packed {
      logic       is_space;
      logic [1:0] kind;
   } space_class_type;

   function automatic space_class_type classify_space(input logic [7:0] c);
      space_class_type r;
      r.is_space = 1'b1;
      r.kind     = KIND_SPACE;
      unique case (c)
         8'h20:   r.kind = KIND_SPACE;
         8'h09:   r.kind = KIND_TAB;
         8'h0B:   r.kind = KIND_VT;
         8'h0C:   r.kind = KIND_FF;
         default: r.is_space = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] space_char(input logic [1:0] kind);
      logic [7:0] r;
      unique case (kind)
         KIND_SPACE: r = 8'h20;
         KIND_TAB:   r = 8'h09;
         KIND_VT:    r = 8'h0B;
         KIND_FF:    r = 8'h0C;
         default:    r = 8'h20;
      endcase
      return r;
   endfunction

endpackage

[design/csv_field_tokenizer.sv]
// Top level of the streaming CSV field tokenizer.
//
// Requests carry req_func (0 = one text byte, 1 = end of data) and req_text_byte.
// Each request yields zero or more responses: dequoted, trimmed content bytes
// (rsp_has_byte) and field ends (rsp_field_end, with rsp_row_end on the last
// field of a row); rsp_last_of_step marks the final response of a request.
// A request that yields at most one response leaves the block idle, and its
// response appears in the output register on the next cycle; the next request
// may be taken in the same cycle as that response leaves.
// Whitespace after field content is held in a small synchronous memory and is
// only released by a later non-whitespace byte of the same field. A release
// of N held characters reads the memory once per character, the first read as
// the request is taken; req_stall stays high until the releasing byte is registered.
// Synchronous reset clears the line, quote and field state and empties the
// output register; the whitespace memory needs no clearing.
// While rsp_stall is high the output register holds its response, and the
// block stops taking requests or releasing held whitespace until it drains.
module csv_field_tokenizer #(
   parameter int FIELD_MAX = csvt_pkg::FIELD_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_byte,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_field_end,
   output logic       rsp_row_end,
   output logic       rsp_last_of_step
);

   localparam int CNT_W = (FIELD_MAX > 2) ? $clog2(FIELD_MAX) : 1;
   localparam logic [CNT_W-1:0] STORE_LIMIT = CNT_W'(FIELD_MAX - 1);

   csvt_pkg::state_type state_ff, state_in;

   logic             in_quote_ff, in_quote_in;
   logic             quote_pending_ff, quote_pending_in;
   logic             line_stopped_ff, line_stopped_in;
   logic             line_nonempty_ff, line_nonempty_in;
   logic             leading_ff, leading_in;
   logic [CNT_W-1:0] stored_count_ff, stored_count_in;
   logic [CNT_W-1:0] pending_count_ff, pending_count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       held_byte_ff, held_byte_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_has_byte_ff, rsp_has_byte_in;
   logic [7:0]       rsp_out_byte_ff, rsp_out_byte_in;
   logic             rsp_field_end_ff, rsp_field_end_in;
   logic             rsp_row_end_ff, rsp_row_end_in;
   logic             rsp_last_ff, rsp_last_in;

   // Held whitespace kinds, one entry per held character of the open field.
   logic [1:0]       kind_mem [FIELD_MAX];
   logic [1:0]       rd_kind_ff;
   logic             mem_we;
   logic [CNT_W-1:0] mem_waddr;
   logic [1:0]       mem_wdata;
   logic             mem_re;
   logic [CNT_W-1:0] mem_raddr;

   logic             out_free;
   logic             accept;
   logic             store_en;
   logic [7:0]       store_char;
   logic             quote_now;
   csvt_pkg::space_class_type cls;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == csvt_pkg::ST_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign cls       = csvt_pkg::classify_space(store_char);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         kind_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_kind_ff <= kind_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= csvt_pkg::ST_IDLE;
         in_quote_ff      <= 1'b0;
         quote_pending_ff <= 1'b0;
         line_stopped_ff  <= 1'b0;
         line_nonempty_ff <= 1'b0;
         leading_ff       <= 1'b1;
         stored_count_ff  <= '0;
         pending_count_ff <= '0;
         idx_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         in_quote_ff      <= in_quote_in;
         quote_pending_ff <= quote_pending_in;
         line_stopped_ff  <= line_stopped_in;
         line_nonempty_ff <= line_nonempty_in;
         leading_ff       <= leading_in;
         stored_count_ff  <= stored_count_in;
         pending_count_ff <= pending_count_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff     <= held_byte_in;
      rsp_has_byte_ff  <= rsp_has_byte_in;
      rsp_out_byte_ff  <= rsp_out_byte_in;
      rsp_field_end_ff <= rsp_field_end_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_last_ff      <= rsp_last_in;
   end

   always_comb begin
      state_in         = state_ff;
      in_quote_in      = in_quote_ff;
      quote_pending_in = quote_pending_ff;
      line_stopped_in  = line_stopped_ff;
      line_nonempty_in = line_nonempty_ff;
      leading_in       = leading_ff;
      stored_count_in  = stored_count_ff;
      pending_count_in = pending_count_ff;
      idx_in           = idx_ff;
      held_byte_in     = held_byte_ff;

      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_has_byte_in  = rsp_has_byte_ff;
      rsp_out_byte_in  = rsp_out_byte_ff;
      rsp_field_end_in = rsp_field_end_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_last_in      = rsp_last_ff;

      mem_we    = 1'b0;
      mem_waddr = pending_count_ff;
      mem_wdata = cls.kind;
      mem_re    = 1'b0;
      mem_raddr = '0;

      store_en   = 1'b0;
      store_char = req_text_byte;
      quote_now  = in_quote_ff;

      unique case (state_ff)
         csvt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == csvt_pkg::FUNC_FLUSH ||
                   req_text_byte == csvt_pkg::CHAR_NEWLINE) begin
                  if (line_nonempty_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_has_byte_in  = 1'b0;
                     rsp_out_byte_in  = '0;
                     rsp_field_end_in = 1'b1;
                     rsp_row_end_in   = 1'b1;
                     rsp_last_in      = 1'b1;
                  end
                  in_quote_in      = 1'b0;
                  quote_pending_in = 1'b0;
                  line_stopped_in  = 1'b0;
                  line_nonempty_in = 1'b0;
                  leading_in       = 1'b1;
                  stored_count_in  = '0;
                  pending_count_in = '0;
               end else if (!line_stopped_ff) begin
                  line_nonempty_in = 1'b1;
                  quote_pending_in = 1'b0;
                  if (quote_pending_ff && req_text_byte == csvt_pkg::CHAR_QUOTE) begin
                     // A doubled quote inside quotes is one literal quote.
                     store_en = 1'b1;
                  end else begin
                     if (quote_pending_ff) begin
                        quote_now   = 1'b0;
                        in_quote_in = 1'b0;
                     end
                     if (req_text_byte == csvt_pkg::CHAR_NUL ||
                         req_text_byte == csvt_pkg::CHAR_CR) begin
                        line_stopped_in = 1'b1;
                     end else if (req_text_byte == csvt_pkg::CHAR_QUOTE) begin
                        if (quote_now) begin
                           quote_pending_in = 1'b1;
                        end else begin
                           in_quote_in = 1'b1;
                        end
                     end else if (req_text_byte == csvt_pkg::CHAR_COMMA && !quote_now) begin
                        rsp_valid_in     = 1'b1;
                        rsp_has_byte_in  = 1'b0;
                        rsp_out_byte_in  = '0;
                        rsp_field_end_in = 1'b1;
                        rsp_row_end_in   = 1'b0;
                        rsp_last_in      = 1'b1;
                        leading_in       = 1'b1;
                        stored_count_in  = '0;
                        pending_count_in = '0;
                     end else begin
                        store_en = 1'b1;
                     end
                  end

                  if (store_en && stored_count_ff < STORE_LIMIT) begin
                     stored_count_in = stored_count_ff + 1'b1;
                     if (cls.is_space) begin
                        if (!leading_ff) begin
                           mem_we           = 1'b1;
                           pending_count_in = pending_count_ff + 1'b1;
                        end
                     end else begin
                        leading_in = 1'b0;
                        if (pending_count_ff != '0) begin
                           // Release held whitespace first, then this byte.
                           held_byte_in = store_char;
                           mem_re       = 1'b1;
                           mem_raddr    = '0;
                           idx_in       = '0;
                           state_in     = csvt_pkg::ST_SPACE;
                        end else begin
                           rsp_valid_in     = 1'b1;
                           rsp_has_byte_in  = 1'b1;
                           rsp_out_byte_in  = store_char;
                           rsp_field_end_in = 1'b0;
                           rsp_row_end_in   = 1'b0;
                           rsp_last_in      = 1'b1;
                        end
                     end
                  end
               end
            end
         end

         csvt_pkg::ST_SPACE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_byte_in  = 1'b1;
               rsp_out_byte_in  = csvt_pkg::space_char(rd_kind_ff);
               rsp_field_end_in = 1'b0;
               rsp_row_end_in   = 1'b0;
               rsp_last_in      = 1'b0;
               if (idx_ff + 1'b1 == pending_count_ff) begin
                  state_in = csvt_pkg::ST_BYTE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_ff + 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end

         csvt_pkg::ST_BYTE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_has_byte_in  = 1'b1;
               rsp_out_byte_in  = held_byte_ff;
               rsp_field_end_in = 1'b0;
               rsp_row_end_in   = 1'b0;
               rsp_last_in      = 1'b1;
               pending_count_in = '0;
               state_in         = csvt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = csvt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_byte     = rsp_has_byte_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_field_end    = rsp_field_end_ff;
   assign rsp_row_end      = rsp_row_end_ff;
   assign rsp_last_of_step = rsp_last_ff;

endmodule

[tb/sv/tb_csv_field_tokenizer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the streaming CSV field tokenizer.
module tb_csv_field_tokenizer;

   localparam int FIELD_LIMIT  = csvt_pkg::FIELD_MAX_DEFAULT;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] out_byte;
      logic       field_end;
      logic       row_end;
      logic       last_of_step;
   } token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_func = csvt_pkg::FUNC_BYTE;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_has_byte;
   logic [7:0] rsp_out_byte;
   logic       rsp_field_end;
   logic       rsp_row_end;
   logic       rsp_last_of_step;

   csv_field_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_field_end    (rsp_field_end),
      .rsp_row_end      (rsp_row_end),
      .rsp_last_of_step (rsp_last_of_step)
   );

   always #5 clock = ~clock;

   // Tokenizer state as predicted from the accepted requests.
   bit       in_quote;
   bit       quote_pending;
   bit       line_stopped;
   bit       line_nonempty;
   bit       in_leading;
   bit [5:0] stored_cnt;
   bit [5:0] held_cnt;
   bit [1:0] held_kind [64];

   token_type tokens_due[$];
   int        step_results;
   int        error_count = 0;
   int        items_sent = 0;
   int        cycle_count = 0;
   int        hold_left = 0;
   int        stall_burst = 0;
   bit        sender_idling = 1'b1;
   bit        receiver_idling = 1'b1;

   function automatic int whitespace_kind(input logic [7:0] c);
      case (c)
         8'h20:   return int'(csvt_pkg::KIND_SPACE);
         8'h09:   return int'(csvt_pkg::KIND_TAB);
         8'h0B:   return int'(csvt_pkg::KIND_VT);
         8'h0C:   return int'(csvt_pkg::KIND_FF);
         default: return -1;
      endcase
   endfunction

   function automatic logic [7:0] whitespace_char(input logic [1:0] k);
      case (k)
         csvt_pkg::KIND_SPACE: return 8'h20;
         csvt_pkg::KIND_TAB:   return 8'h09;
         csvt_pkg::KIND_VT:    return 8'h0B;
         default:              return 8'h0C;
      endcase
   endfunction

   function automatic void add_token(input bit hb, input logic [7:0] b, input bit fe,
                                     input bit re);
      token_type t;
      t.has_byte     = hb;
      t.out_byte     = b;
      t.field_end    = fe;
      t.row_end      = re;
      t.last_of_step = 1'b0;
      tokens_due.push_back(t);
      step_results++;
   endfunction

   function automatic void clear_field();
      in_leading = 1'b1;
      stored_cnt = '0;
      held_cnt   = '0;
   endfunction

   function automatic void clear_line();
      in_quote      = 1'b0;
      quote_pending = 1'b0;
      line_stopped  = 1'b0;
      line_nonempty = 1'b0;
      clear_field();
   endfunction

   // Whitespace after content is held until a stored non-whitespace byte releases it.
   function automatic void store_content(input logic [7:0] c);
      int k;
      k = whitespace_kind(c);
      if (stored_cnt < FIELD_LIMIT - 1) begin
         stored_cnt++;
         if (k >= 0) begin
            if (!in_leading) begin
               held_kind[held_cnt] = k[1:0];
               held_cnt++;
            end
         end else begin
            in_leading = 1'b0;
            for (int i = 0; i < held_cnt; i++)
               add_token(1'b1, whitespace_char(held_kind[i]), 1'b0, 1'b0);
            held_cnt = '0;
            add_token(1'b1, c, 1'b0, 1'b0);
         end
      end
   endfunction

   function automatic void tokenize_request(input logic f, input logic [7:0] c);
      token_type t;
      bit        handled;
      step_results = 0;
      handled = 1'b0;
      if (f == csvt_pkg::FUNC_FLUSH || c == csvt_pkg::CHAR_NEWLINE) begin
         if (line_nonempty)
            add_token(1'b0, 8'h00, 1'b1, 1'b1);
         clear_line();
      end else if (!line_stopped) begin
         line_nonempty = 1'b1;
         // A quote inside quotes is either an escaped quote or the closing one.
         if (quote_pending) begin
            quote_pending = 1'b0;
            if (c == csvt_pkg::CHAR_QUOTE) begin
               store_content(csvt_pkg::CHAR_QUOTE);
               handled = 1'b1;
            end else begin
               in_quote = 1'b0;
            end
         end
         if (!handled) begin
            if (c == csvt_pkg::CHAR_NUL || c == csvt_pkg::CHAR_CR) begin
               line_stopped = 1'b1;
            end else if (c == csvt_pkg::CHAR_QUOTE) begin
               if (in_quote)
                  quote_pending = 1'b1;
               else
                  in_quote = 1'b1;
            end else if (c == csvt_pkg::CHAR_COMMA && !in_quote) begin
               add_token(1'b0, 8'h00, 1'b1, 1'b0);
               clear_field();
            end else begin
               store_content(c);
            end
         end
      end
      if (step_results > 0) begin
         t = tokens_due.pop_back();
         t.last_of_step = 1'b1;
         tokens_due.push_back(t);
      end
   endfunction

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_responses
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report_error("response with no request pending");
         end else begin
            want = tokens_due.pop_front();
            check_field("has_byte", 8'(rsp_has_byte), 8'(want.has_byte));
            check_field("out_byte", rsp_out_byte, want.out_byte);
            check_field("field_end", 8'(rsp_field_end), 8'(want.field_end));
            check_field("row_end", 8'(rsp_row_end), 8'(want.row_end));
            check_field("last_of_step", 8'(rsp_last_of_step), 8'(want.last_of_step));
         end
      end
   end

   // Receiver: a long hold when a test asks for one, else random stall bursts while receiver_idling is set.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_burst > 0) begin
         rsp_stall <= 1'b1;
         stall_burst--;
      end else if (receiver_idling && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_burst = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(input logic f, input logic [7:0] c);
      @(negedge clock);
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_text_byte <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_request(f, c);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_request(csvt_pkg::FUNC_BYTE, s[i]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_space();
      return whitespace_char(2'($urandom_range(0, 3)));
   endfunction

   function automatic logic [7:0] random_plain();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == csvt_pkg::CHAR_NUL || c == csvt_pkg::CHAR_NEWLINE ||
             c == csvt_pkg::CHAR_CR || c == csvt_pkg::CHAR_QUOTE ||
             c == csvt_pkg::CHAR_COMMA || whitespace_kind(c) >= 0);
      return c;
   endfunction

   task automatic send_random_field();
      int len;
      int r;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            repeat ($urandom_range(0, 2)) send_request(csvt_pkg::FUNC_BYTE, random_space());
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_request(csvt_pkg::FUNC_BYTE,
                            ($urandom_range(0, 3) == 0) ? random_space() : random_plain());
            repeat ($urandom_range(0, 2)) send_request(csvt_pkg::FUNC_BYTE, random_space());
         end
         4, 5: begin
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 5);
               if (r == 0) begin
                  send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
                  send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
               end else if (r == 1) begin
                  send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_COMMA);
               end else if (r == 2) begin
                  send_request(csvt_pkg::FUNC_BYTE, random_space());
               end else begin
                  send_request(csvt_pkg::FUNC_BYTE, random_plain());
               end
            end
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
            if ($urandom_range(0, 3) == 0)
               send_request(csvt_pkg::FUNC_BYTE, random_space());
         end
         6: begin
            // Long quoted field that may run past the storage limit.
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
            len = $urandom_range(FIELD_LIMIT - 8, FIELD_LIMIT + 8);
            for (int i = 0; i < len; i++) begin
               r = $urandom_range(0, 7);
               if (r == 0) begin
                  send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
                  send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
               end else if (r == 1) begin
                  send_request(csvt_pkg::FUNC_BYTE, random_space());
               end else begin
                  send_request(csvt_pkg::FUNC_BYTE, random_plain());
               end
            end
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_QUOTE);
         end
         7: begin
            send_request(csvt_pkg::FUNC_BYTE, random_plain());
            repeat ($urandom_range(1, FIELD_LIMIT - 3))
               send_request(csvt_pkg::FUNC_BYTE, random_space());
            send_request(csvt_pkg::FUNC_BYTE, random_plain());
         end
         8: begin
            // An empty field.
         end
         default: begin
            repeat ($urandom_range(1, 4))
               send_request(($urandom_range(0, 9) == 0) ? csvt_pkg::FUNC_FLUSH
                                                        : csvt_pkg::FUNC_BYTE,
                            8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task automatic send_random_row();
      int fields;
      fields = $urandom_range(1, 4);
      for (int i = 0; i < fields; i++) begin
         if (i > 0)
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_COMMA);
         send_random_field();
      end
      case ($urandom_range(0, 7))
         0: send_request(csvt_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
         1: begin
            send_request(csvt_pkg::FUNC_BYTE, ($urandom_range(0, 1) == 0) ? csvt_pkg::CHAR_CR
                                                                         : csvt_pkg::CHAR_NUL);
            send_request(csvt_pkg::FUNC_BYTE, random_plain());
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_COMMA);
            send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_NEWLINE);
         end
         default: send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_NEWLINE);
      endcase
   endtask

   task automatic test_plain_fields();
      send_text("a,");
      send_request(csvt_pkg::FUNC_BYTE, 8'hFF);
      send_request(csvt_pkg::FUNC_BYTE, 8'h80);
      send_text("\n\n");
   endtask

   // Escaped quote, comma inside quotes, closing quote followed by content,
   // and a newline inside quotes.
   task automatic test_quoting();
      send_text("\"a\"\"b,\"x,\"p\n");
   endtask

   task automatic test_line_stop();
      send_text("a");
      send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_CR);
      send_text(",b\n");
      send_request(csvt_pkg::FUNC_BYTE, csvt_pkg::CHAR_NUL);
      send_text("\n");
   endtask

   task automatic test_trimming();
      send_text(" \ta");
      send_request(csvt_pkg::FUNC_BYTE, 8'h0B);
      send_request(csvt_pkg::FUNC_BYTE, 8'h0C);
      send_text(" b ,\n");
   endtask

   task automatic test_flush();
      send_request(csvt_pkg::FUNC_FLUSH, 8'h00);
      send_text("z");
      send_request(csvt_pkg::FUNC_FLUSH, 8'hFF);
      send_request(csvt_pkg::FUNC_FLUSH, 8'h55);
   endtask

   // The receiver holds off while a long release and a full field go in,
   // so the block backs up and stalls its input.
   task automatic test_backpressure();
      hold_left = 150;
      send_text("a");
      repeat (40) send_request(csvt_pkg::FUNC_BYTE, random_space());
      send_text("b,\"");
      repeat (FIELD_LIMIT - 2) send_request(csvt_pkg::FUNC_BYTE, random_plain());
      send_text("\"\"\"\"y\"\n");
   endtask

   task automatic test_pause_until_drained();
      send_text("p,q");
      wait_drained();
      send_text("r\n");
   endtask

   task automatic test_random_rows();
      int target;
      target = items_sent + 180;
      while (items_sent < target) send_random_row();
   endtask

   task automatic test_random_rows_steady();
      int target;
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      target = items_sent + 60;
      while (items_sent < target) send_random_row();
   endtask

   initial begin
      clear_line();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_plain_fields();
      test_quoting();
      test_line_stop();
      test_trimming();
      test_flush();
      test_backpressure();
      test_pause_until_drained();
      test_random_rows();
      test_random_rows_steady();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
design/csvt_pkg.sv
design/csv_field_tokenizer.sv
tb/sv/tb_csv_field_tokenizer.sv
